FILE: rtl/adb_pkg.sv
// Shared types and constants for the antialiased disk blend block.
package adb_pkg;

    localparam int MAX_RADIUS_DEF = 64;
    localparam int RAD_W          = 7;
    localparam int POS_W          = 7;
    localparam int CH_W           = 8;
    localparam int SUB            = 16;
    localparam int SUB_W          = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_END   = 2'd2;

    localparam logic [RAD_W-1:0]      RADIUS_RST = 7'd8;
    localparam logic [CFG_DATA_W-1:0] COLOR_RST  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [CH_W-1:0]  dst_blue;
        logic [CH_W-1:0]  dst_green;
        logic [CH_W-1:0]  dst_red;
        logic [CH_W-1:0]  dst_alpha;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_alpha;
    } t_out_beat;

endpackage

FILE: rtl/adb_cover.sv
// Three-stage subsample coverage counter for one mirrored pixel.
module adb_cover #(
    parameter int RW = 7
) (
    input  logic                      i_clk,
    input  logic [2:0]                i_en,
    input  logic [RW-1:0]             i_qc,
    input  logic [RW-1:0]             i_qr,
    input  logic [RW-1:0]             i_rr,
    output logic [adb_pkg::CH_W-1:0]  o_cov
);
    import adb_pkg::*;

    localparam int DW  = RW + SUB_W;
    localparam int SQW = 2 * DW;

    logic [DW-1:0]  bx, by, lr;
    logic [DW-1:0]  dx [SUB];
    logic [DW-1:0]  dy [SUB];
    logic [SQW-1:0] n_sqx [SUB];
    logic [SQW-1:0] n_sqy [SUB];
    logic [SQW-1:0] n_lim;
    logic [SQW-1:0] r_sqx [SUB];
    logic [SQW-1:0] r_sqy [SUB];
    logic [SQW-1:0] r_lim;
    logic [SUB-1:0] hit [SUB];
    logic [4:0]     n_cnt [SUB];
    logic [4:0]     r_cnt [SUB];
    logic [5:0]     s1 [8];
    logic [6:0]     s2 [4];
    logic [7:0]     s3 [2];
    logic [8:0]     s4;
    logic [CH_W-1:0] n_cov, r_cov;

    // Stage one: squared subsample offsets along each axis.
    always_comb begin
        bx = {RW'(i_rr - i_qc), {SUB_W{1'b0}}};
        by = {RW'(i_rr - i_qr), {SUB_W{1'b0}}};
        lr = {i_rr, {SUB_W{1'b0}}};
        n_lim = SQW'(lr) * SQW'(lr);
        for (int k = 0; k < SUB; k++) begin
            dx[k] = bx - DW'(k);
            dy[k] = by - DW'(k);
            n_sqx[k] = SQW'(dx[k]) * SQW'(dx[k]);
            n_sqy[k] = SQW'(dy[k]) * SQW'(dy[k]);
        end
    end

    // Stage two: per-column count of subsamples strictly inside the radius.
    always_comb begin
        for (int k = 0; k < SUB; k++) begin
            for (int l = 0; l < SUB; l++) begin
                hit[k][l] = ({1'b0, r_sqx[k]} + {1'b0, r_sqy[l]}) < {1'b0, r_lim};
            end
            n_cnt[k] = 5'($countones(hit[k]));
        end
    end

    // Stage three: adder tree over the column counts, then clamp.
    always_comb begin
        for (int i = 0; i < 8; i++) s1[i] = 6'(r_cnt[2*i]) + 6'(r_cnt[2*i+1]);
        for (int i = 0; i < 4; i++) s2[i] = 7'(s1[2*i]) + 7'(s1[2*i+1]);
        for (int i = 0; i < 2; i++) s3[i] = 8'(s2[2*i]) + 8'(s2[2*i+1]);
        s4 = 9'(s3[0]) + 9'(s3[1]);
        n_cov = s4[8] ? 8'hFF : s4[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
            r_lim <= n_lim;
        end
        if (i_en[1]) begin
            r_cnt <= n_cnt;
        end
        if (i_en[2]) begin
            r_cov <= n_cov;
        end
    end

    assign o_cov = r_cov;

endmodule

FILE: rtl/adb_div.sv
// Four-stage restoring divider giving an 8-bit quotient, two bits per stage.
module adb_div #(
    parameter int NUMW = 16,
    parameter int DENW = 8
) (
    input  logic                     i_clk,
    input  logic [3:0]               i_en,
    input  logic [NUMW-1:0]          i_num,
    input  logic [DENW-1:0]          i_den,
    output logic [adb_pkg::CH_W-1:0] o_quo
);
    import adb_pkg::*;

    localparam int CW = (NUMW > DENW + CH_W) ? NUMW : DENW + CH_W;

    logic [CW-1:0]   r_rem [4];
    logic [DENW-1:0] r_den [4];
    logic [CH_W-1:0] r_quo [4];

    for (genvar s = 0; s < 4; s++) begin : g_st
        logic [CW-1:0]   rin, t1, t0, rmid, rout;
        logic [DENW-1:0] din;
        logic [CH_W-1:0] qin, qout;

        if (s == 0) begin : g_first
            assign rin = CW'(i_num);
            assign din = i_den;
            assign qin = '0;
        end else begin : g_next
            assign rin = r_rem[s-1];
            assign din = r_den[s-1];
            assign qin = r_quo[s-1];
        end

        // The quotient is known to stay below 256, so each trial keeps the
        // remainder below the next shifted divisor.
        always_comb begin
            qout = qin;
            t1 = CW'(din) << (7 - 2 * s);
            t0 = CW'(din) << (6 - 2 * s);
            rmid = rin;
            if (rin >= t1) begin
                rmid = rin - t1;
                qout[7 - 2 * s] = 1'b1;
            end
            rout = rmid;
            if (rmid >= t0) begin
                rout = rmid - t0;
                qout[6 - 2 * s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= rout;
                r_den[s] <= din;
                r_quo[s] <= qout;
            end
        end
    end

    assign o_quo = r_quo[3];

endmodule

FILE: rtl/adb_blend.sv
// Two-stage source-over blend of the gradient color onto the destination.
module adb_blend (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic [2:0][adb_pkg::CH_W-1:0] i_src,
    input  logic [adb_pkg::CH_W-1:0]      i_sa,
    input  logic [3:0][adb_pkg::CH_W-1:0] i_dst,
    output adb_pkg::t_out_beat            o_data
);
    import adb_pkg::*;

    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [2:0][15:0] n_mix, r_mix;
    logic [15:0]      n_amix, r_amix;
    logic [CH_W-1:0]  inv_sa, r_sa;
    t_out_beat        n_out, r_out;

    always_comb begin
        inv_sa = 8'hFF - i_sa;
        for (int c = 0; c < 3; c++) begin
            n_mix[c] = 16'(i_src[c]) * 16'(i_sa) + 16'(i_dst[c]) * 16'(inv_sa);
        end
        n_amix = 16'(i_dst[3]) * 16'(inv_sa);
    end

    always_comb begin
        n_out.out_blue  = div255(r_mix[0]);
        n_out.out_green = div255(r_mix[1]);
        n_out.out_red   = div255(r_mix[2]);
        n_out.out_alpha = r_sa + div255(r_amix);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mix  <= n_mix;
            r_amix <= n_amix;
            r_sa   <= i_sa;
        end
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

FILE: rtl/antialiased_disk_blend.sv
// Antialiased disk blend: top level with configuration, pipeline control and datapath.
// An accepted input beat passes through stage registers 1 to 11 on its way to its output beat.
// Throughput is one beat per cycle while i_stall is low, since every one of the 11 stages can load each cycle.
// Each stage holds while its successor is full and stalled, so bubbles are squeezed out.
// Reset is synchronous and active low: it clears all stage valid bits and
// returns radius to 8 and both gradient colors to all ones.
module antialiased_disk_blend #(
    parameter int MAX_RADIUS = adb_pkg::MAX_RADIUS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  adb_pkg::t_in_beat                 i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output adb_pkg::t_out_beat                o_data,
    input  logic                              i_cfg_wr_en,
    input  logic [adb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [adb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import adb_pkg::*;

    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int SPW  = RW + 1;
    localparam int NW   = CH_W + SPW;
    localparam int PW   = CH_W + NW;
    localparam int DVW  = CH_W + SPW;
    localparam logic [8:0] MAXR9 = 9'(MAX_RADIUS);

    typedef struct packed {
        logic [2:0][NW-1:0]   num;
        logic [NW-1:0]        anum;
        logic [SPW-1:0]       span;
        logic [3:0][CH_W-1:0] dst;
    } t_mid;

    typedef struct packed {
        logic [2:0][NW-1:0]   num;
        logic [PW-1:0]        prod;
        logic [DVW-1:0]       aden;
        logic [SPW-1:0]       span;
        logic [3:0][CH_W-1:0] dst;
    } t_div_in;

    logic [RAD_W-1:0]      r_radius;
    logic [CFG_DATA_W-1:0] r_color_start, r_color_end;

    logic [11:1] en, r_v;

    logic [8:0] rad9, rsel9, span9, col9, row9, colc9, rowc9, qc9, qr9;
    logic [RW-1:0]  r1_qc, r1_qr, r1_rr;
    logic [SPW-1:0] r1_row, r1_span;
    logic [3:0][CH_W-1:0] r1_dst;

    t_mid    n2_mid;
    t_mid    r_mid [2:4];
    logic [CH_W-1:0] cov;
    t_div_in n5, r5;
    logic [3:0][CH_W-1:0] r_dd [6:9];
    logic [2:0][CH_W-1:0] quo;
    logic [CH_W-1:0]      sa;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_RST;
            r_color_start <= COLOR_RST;
            r_color_end   <= COLOR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_RADIUS:      r_radius      <= i_cfg_wdata[RAD_W-1:0];
                REG_COLOR_START: r_color_start <= i_cfg_wdata;
                REG_COLOR_END:   r_color_end   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        en[11] = !r_v[11] || !i_stall;
        for (int k = 10; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= 11; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 1) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[11];

    // Stage 1: clamp radius and position, mirror into the top-left quadrant.
    always_comb begin
        rad9 = {2'b00, r_radius};
        if (rad9 == 9'd0) begin
            rsel9 = 9'd1;
        end else if (rad9 > MAXR9) begin
            rsel9 = MAXR9;
        end else begin
            rsel9 = rad9;
        end
        span9 = {rsel9[7:0], 1'b0};
        col9  = {2'b00, i_data.col};
        row9  = {2'b00, i_data.row};
        colc9 = (col9 >= span9) ? span9 - 9'd1 : col9;
        rowc9 = (row9 >= span9) ? span9 - 9'd1 : row9;
        qc9   = (colc9 < rsel9) ? colc9 : span9 - 9'd1 - colc9;
        qr9   = (rowc9 < rsel9) ? rowc9 : span9 - 9'd1 - rowc9;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_qc   <= qc9[RW-1:0];
            r1_qr   <= qr9[RW-1:0];
            r1_rr   <= rsel9[RW-1:0];
            r1_row  <= rowc9[SPW-1:0];
            r1_span <= span9[SPW-1:0];
            r1_dst  <= {i_data.dst_alpha, i_data.dst_red, i_data.dst_green, i_data.dst_blue};
        end
    end

    // Stages 2 to 4: coverage count.
    adb_cover #(
        .RW (RW)
    ) u_cover (
        .i_clk (i_clk),
        .i_en  (en[4:2]),
        .i_qc  (r1_qc),
        .i_qr  (r1_qr),
        .i_rr  (r1_rr),
        .o_cov (cov)
    );

    // Stage 2: gradient numerators, c*(span-row) + c1*row, never negative.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_mid.num[c] = NW'(r_color_start[8*c +: 8]) * NW'(r1_span - r1_row)
                          + NW'(r_color_end[8*c +: 8]) * NW'(r1_row);
        end
        n2_mid.anum = NW'(r_color_start[31:24]) * NW'(r1_span - r1_row)
                    + NW'(r_color_end[31:24]) * NW'(r1_row);
        n2_mid.span = r1_span;
        n2_mid.dst  = r1_dst;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) r_mid[2] <= n2_mid;
        if (en[3]) r_mid[3] <= r_mid[2];
        if (en[4]) r_mid[4] <= r_mid[3];
    end

    // Stage 5: coverage times gradient alpha, and the alpha divisor 255*span.
    always_comb begin
        n5.num  = r_mid[4].num;
        n5.prod = PW'(cov) * PW'(r_mid[4].anum);
        n5.aden = {r_mid[4].span, 8'h00} - DVW'(r_mid[4].span);
        n5.span = r_mid[4].span;
        n5.dst  = r_mid[4].dst;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) r5 <= n5;
    end

    // Stages 6 to 9: four divider lanes side by side.
    for (genvar c = 0; c < 3; c++) begin : g_cdiv
        adb_div #(
            .NUMW (NW),
            .DENW (SPW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en[9:6]),
            .i_num (r5.num[c]),
            .i_den (r5.span),
            .o_quo (quo[c])
        );
    end

    adb_div #(
        .NUMW (PW),
        .DENW (DVW)
    ) u_adiv (
        .i_clk (i_clk),
        .i_en  (en[9:6]),
        .i_num (r5.prod),
        .i_den (r5.aden),
        .o_quo (sa)
    );

    always_ff @(posedge i_clk) begin
        if (en[6]) r_dd[6] <= r5.dst;
        if (en[7]) r_dd[7] <= r_dd[6];
        if (en[8]) r_dd[8] <= r_dd[7];
        if (en[9]) r_dd[9] <= r_dd[8];
    end

    // Stages 10 and 11: blend and output register.
    adb_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (en[11:10]),
        .i_src  (quo),
        .i_sa   (sa),
        .i_dst  (r_dd[9]),
        .o_data (o_data)
    );

endmodule

FILE: rtl/adb_check.sv
// Port-level checker for the antialiased disk blend, bound to the top level.
module adb_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input adb_pkg::t_out_beat             o_data
);
    import adb_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // An empty or draining output stage lets every earlier stage move.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while the pipeline can move");

endmodule

bind antialiased_disk_blend adb_check u_check (.*);

FILE: verif/antialiased_disk_blend_tb.sv
// Self-checking testbench for the antialiased disk blend block.
`timescale 1ns / 1ps

module antialiased_disk_blend_tb;
    import adb_pkg::*;

    localparam int MAX_R      = 64;
    localparam int RAND_ITEMS = 1830;
    localparam int LIMIT      = 400000;
    localparam int PIPE_LAT   = 11;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_beat              i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out_beat             o_data;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    antialiased_disk_blend dut (.*);

    // Shadow copy of the block's registers.
    int unsigned         disk_radius;
    logic [31:0]         grad_top;
    logic [31:0]         grad_bottom;

    t_out_beat           pending_pixels[$];
    int                  mismatch_cnt;
    int                  cycle_cnt;
    bit                  tx_idle_en;
    bit                  rx_idle_en;
    bit                  hold_rx;
    bit                  sending;

    typedef struct {
        t_in_beat    pix;
        bit          has_exp;
        t_out_beat   exp;
    } t_stim_row;

    function automatic int unsigned ramp_chan(int unsigned a, int unsigned b,
                                              int unsigned pos, int unsigned span);
        if (b >= a) begin
            return a + ((b - a) * pos) / span;
        end
        return a - (((a - b) * pos + span - 1) / span);
    endfunction

    function automatic t_out_beat blend_pixel(t_in_beat p);
        int unsigned r, span, c, rw, qc, qr, cnt, cov, ca, c1a, anum, sa;
        int unsigned g[3];
        int unsigned d[3];
        int          bx, by, lim, dx, dy;
        t_out_beat   res;
        r = disk_radius;
        if (r < 1) r = 1;
        if (r > MAX_R) r = MAX_R;
        span = 2 * r;
        c  = p.col;
        rw = p.row;
        if (c >= span) c = span - 1;
        if (rw >= span) rw = span - 1;
        qc = (c < r) ? c : span - 1 - c;
        qr = (rw < r) ? rw : span - 1 - rw;
        bx = 16 * (int'(r) - int'(qc));
        by = 16 * (int'(r) - int'(qr));
        lim = 16 * int'(r);
        lim = lim * lim;
        cnt = 0;
        for (int k = 0; k < 16; k++) begin
            for (int l = 0; l < 16; l++) begin
                dx = bx - k;
                dy = by - l;
                if (dx * dx + dy * dy < lim) cnt++;
            end
        end
        cov = (cnt > 255) ? 255 : cnt;
        for (int ch = 0; ch < 3; ch++) begin
            g[ch] = ramp_chan(grad_top[8*ch +: 8], grad_bottom[8*ch +: 8], rw, span);
        end
        ca  = grad_top[31:24];
        c1a = grad_bottom[31:24];
        if (c1a >= ca) anum = ca * span + (c1a - ca) * rw;
        else anum = ca * span - (ca - c1a) * rw;
        sa = (cov * anum) / (255 * span);
        if (sa > 255) sa = 255;
        d[0] = p.dst_blue;
        d[1] = p.dst_green;
        d[2] = p.dst_red;
        res.out_blue  = 8'((g[0] * sa + d[0] * (255 - sa)) / 255);
        res.out_green = 8'((g[1] * sa + d[1] * (255 - sa)) / 255);
        res.out_red   = 8'((g[2] * sa + d[2] * (255 - sa)) / 255);
        res.out_alpha = 8'(sa + (p.dst_alpha * (255 - sa)) / 255);
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: compare each accepted beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected beat %h", o_data);
            end else begin
                want = pending_pixels.pop_front();
                if (want.out_blue !== o_data.out_blue || want.out_green !== o_data.out_green
                    || want.out_red !== o_data.out_red
                    || want.out_alpha !== o_data.out_alpha) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("pixel mismatch: expected %h got %h", want, o_data);
                end
            end
        end
    end

    // Receiver stall, in bursts, or held off for a long stretch on request.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_rx = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_RADIUS:      disk_radius = val[6:0];
            REG_COLOR_START: grad_top = val;
            REG_COLOR_END:   grad_bottom = val;
            default: ;
        endcase
    endtask

    // Sends one beat; called at a falling edge, returns at a falling edge.
    task automatic send_pixel(t_in_beat p, bit has_exp, t_out_beat exp);
        t_out_beat want;
        int n;
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        want = blend_pixel(p);
        if (has_exp && want != exp) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("table row disagrees: %h vs %h", exp, want);
        end
        i_valid <= 1'b1;
        i_data  <= p;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    function automatic t_in_beat rand_pixel(int unsigned r);
        t_in_beat p;
        p = t_in_beat'({$urandom, 14'($urandom)});
        // Mostly inside the box; sometimes anywhere to hit saturation.
        if ($urandom_range(0, 9) != 0 && r >= 1 && r <= MAX_R) begin
            p.col = 7'($urandom_range(0, 2 * r - 1));
            p.row = 7'($urandom_range(0, 2 * r - 1));
        end
        return p;
    endfunction

    initial begin
        t_stim_row dir_rows[$];
        t_stim_row row_e;
        logic [31:0] radii[7];
        t_in_beat p;
        int per_phase;
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_rx      = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = REG_RADIUS;
        i_cfg_wdata  = '0;
        disk_radius  = RADIUS_RST;
        grad_top     = COLOR_RST;
        grad_bottom  = COLOR_RST;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at reset settings: white disk of radius 8.
        // Center pixel fully covered: opaque white regardless of destination.
        row_e.pix = '{col: 7, row: 7, dst_blue: 0, dst_green: 0, dst_red: 0,
                      dst_alpha: 0};
        row_e.has_exp = 1;
        row_e.exp = '{out_blue: 8'hFF, out_green: 8'hFF, out_red: 8'hFF,
                      out_alpha: 8'hFF};
        dir_rows.push_back(row_e);
        // Corner pixel has no coverage: destination passes through.
        row_e.pix = '{col: 0, row: 0, dst_blue: 8'h12, dst_green: 8'h34,
                      dst_red: 8'h56, dst_alpha: 8'h78};
        row_e.exp = '{out_blue: 8'h12, out_green: 8'h34, out_red: 8'h56,
                      out_alpha: 8'h78};
        dir_rows.push_back(row_e);
        row_e.has_exp = 0;
        foreach (radii[i]) begin
            row_e.pix = '{col: 7'h7F, row: 7'h7F, dst_blue: 8'hFF, dst_green: 8'hFF,
                          dst_red: 8'hFF, dst_alpha: 8'hFF};
            if (i % 2 == 1) row_e.pix = '{col: 15, row: 8, dst_blue: 8'hAA,
                                          dst_green: 8'h55, dst_red: 0, dst_alpha: 8'h80};
            dir_rows.push_back(row_e);
        end
        for (int i = 0; i < 8; i++) begin
            row_e.pix = '{col: 7'(i * 2), row: 7'(15 - i), dst_blue: 8'(i * 31),
                          dst_green: 8'(255 - i * 31), dst_red: 8'(i * 17),
                          dst_alpha: 8'(i * 40)};
            dir_rows.push_back(row_e);
        end
        foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].has_exp,
                                         dir_rows[i].exp);
        drain();

        // Radius extremes, including the out-of-range zero and oversize values.
        radii = '{0, 1, 64, 127, 65, 3, 8};
        per_phase = RAND_ITEMS / 10;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin write_reg(REG_COLOR_START, 32'h0000_0000);
                         write_reg(REG_COLOR_END, 32'hFFFF_FFFF); end
                1: begin write_reg(REG_COLOR_START, 32'hFFFF_FFFF);
                         write_reg(REG_COLOR_END, 32'h0000_0000); end
                9: ; // keep the previous colors for the final quiet phase
                default: begin write_reg(REG_COLOR_START, $urandom);
                               write_reg(REG_COLOR_END, $urandom); end
            endcase
            write_reg(REG_RADIUS, (ph < 7) ? radii[ph] : $urandom_range(1, 127));
            // Unused register index must leave everything untouched.
            if (ph == 4) write_reg(REG_SPARE, $urandom);
            if (ph == 5) hold_rx = 1'b1;
            if (ph == 9) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            for (int i = 0; i < per_phase; i++) begin
                p = rand_pixel(disk_radius);
                send_pixel(p, 0, '0);
            end
            drain();
        end

        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
